[rtl/b2a_pkg.sv]
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants for binary_to_ascii_digits
// Widths of the digit store and counters, command/status structs between the
// controller and the datapath, and the nibble to ascii mapping.
// ----------------------------------------------------------------------------
package b2a_pkg;

  // input value width and number of digit slots (2^64-1 has 20 decimal digits)
  localparam int VAL_W     = 64;
  localparam int DIGITS    = 20;
  localparam int NIB_W     = 4;
  localparam int BCD_W     = DIGITS * NIB_W;
  localparam int CNT_W     = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W = $clog2(VAL_W);
  localparam int CHAR_W    = 7;

  // ascii anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [NIB_W-1:0]  NIB_TEN   = 4'd10;

  // commands from the controller
  typedef struct packed {
    logic load;       // take the input value
    logic load_hex;   // load nibbles directly instead of starting a conversion
    logic dabble;     // one shift-add-3 step
    logic shift;      // drop the top digit
  } b2a_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic top_zero;   // top digit slot holds zero
    logic last;       // one digit left
  } b2a_stat_t;

  // nibble to ascii, upper-case hex letters
  function automatic logic [CHAR_W-1:0] nib_to_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(nib);
    if (nib < NIB_TEN) begin
      nib_to_char = CHAR_ZERO + ext;
    end else begin
      nib_to_char = CHAR_A + ext - CHAR_W'(NIB_TEN);
    end
  endfunction

endpackage

[rtl/b2a_dp.sv]
// ----------------------------------------------------------------------------
// b2a_dp: digit datapath
// Holds the binary shift register, the 20 bcd/hex digit slots and the count of
// digits left. Runs double-dabble steps and shifts digits out from the top.
// ----------------------------------------------------------------------------
module b2a_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b2a_pkg::b2a_cmd_t            cmd,
  input  logic [b2a_pkg::VAL_W-1:0]    value,
  output b2a_pkg::b2a_stat_t           stat,
  output logic [b2a_pkg::CHAR_W-1:0]   digit_char
);

  logic [b2a_pkg::BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [b2a_pkg::VAL_W-1:0] bin_r, bin_nxt;
  logic [b2a_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [b2a_pkg::NIB_W-1:0] top_nib;

  // add-3 correction on every digit slot
  always_comb begin
    for (int i = 0; i < b2a_pkg::DIGITS; i++) begin
      if (bcd_r[i*b2a_pkg::NIB_W +: b2a_pkg::NIB_W] >= 4'd5) begin
        bcd_adj[i*b2a_pkg::NIB_W +: b2a_pkg::NIB_W] =
          bcd_r[i*b2a_pkg::NIB_W +: b2a_pkg::NIB_W] + 4'd3;
      end else begin
        bcd_adj[i*b2a_pkg::NIB_W +: b2a_pkg::NIB_W] =
          bcd_r[i*b2a_pkg::NIB_W +: b2a_pkg::NIB_W];
      end
    end
  end

  // next state of the digit store
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = b2a_pkg::CNT_W'(b2a_pkg::DIGITS);
      if (cmd.load_hex) begin
        bcd_nxt = b2a_pkg::BCD_W'(value);
        bin_nxt = '0;
      end else begin
        bcd_nxt = '0;
        bin_nxt = value;
      end
    end else if (cmd.dabble) begin
      bcd_nxt = {bcd_adj[b2a_pkg::BCD_W-2:0], bin_r[b2a_pkg::VAL_W-1]};
      bin_nxt = {bin_r[b2a_pkg::VAL_W-2:0], 1'b0};
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_r[b2a_pkg::BCD_W-b2a_pkg::NIB_W-1:0], {b2a_pkg::NIB_W{1'b0}}};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
  end

  // status and output digit
  assign top_nib       = bcd_r[b2a_pkg::BCD_W-1 -: b2a_pkg::NIB_W];
  assign stat.top_zero = (top_nib == '0);
  assign stat.last     = (cnt_r == b2a_pkg::CNT_W'(1));
  assign digit_char    = b2a_pkg::nib_to_char(top_nib);

endmodule

[rtl/b2a_ctrl.sv]
// ----------------------------------------------------------------------------
// b2a_ctrl: sequencing controller
// Accepts an item, runs the 64 conversion steps for decimal, skips leading
// zero digits and then hands out one digit per output transfer.
// ----------------------------------------------------------------------------
module b2a_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b2a_pkg::b2a_cmd_t    cmd,
  input  b2a_pkg::b2a_stat_t   stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [b2a_pkg::BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.load_hex = in_mode;
          bit_cnt_nxt  = '0;
          state_nxt    = in_mode ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble  = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == b2a_pkg::BIT_CNT_W'(b2a_pkg::VAL_W - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (stat.top_zero && !stat.last) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule

[rtl/binary_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// binary_to_ascii_digits: 64-bit unsigned to ascii decimal or hex digits
//
//   channel  direction  payload                  handshake
//   in_      input      value[63:0], mode        in_valid / in_ready
//   out_     output     digit_char[6:0], last    out_valid / out_ready
//
// One item at a time. Decimal: the item is accepted, 64 shift-add-3 steps run in the
// digit datapath, up to 19 leading zero digits are dropped, then the digits go
// out one per output transfer. Hex skips the conversion and goes straight to dropping zeros.
// Reset (synchronous, active low) returns the controller to idle.
// A stalled output holds the current digit; in_ready stays low until the
// final digit has transferred.
// ----------------------------------------------------------------------------
module binary_to_ascii_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [b2a_pkg::VAL_W-1:0]     in_value,
  input  logic                          in_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b2a_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);

  b2a_pkg::b2a_cmd_t  cmd;
  b2a_pkg::b2a_stat_t stat;

  // controller
  b2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  b2a_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_value),
    .stat       (stat),
    .digit_char (out_digit_char)
  );

  assign out_last = stat.last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digits pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("output continues after last digit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted two items back to back");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 7'h30 && out_digit_char <= 7'h39) ||
                   (out_digit_char >= 7'h41 && out_digit_char <= 7'h46)))
    else $error("digit character out of range");

endmodule
